FILE: hw/rtl/beq_pkg.sv
// Shared types, register codes and the threshold table of the band energy quantizer.
package beq_pkg;

    localparam int COEF_W    = 24;
    localparam int BAND_W    = 6;
    localparam int CFG_W     = 7;
    localparam int CODE_W    = 8;
    localparam int SQ_W      = 47;
    localparam int THR_W     = 47;
    localparam int ROM_DEPTH = 256;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    typedef enum logic [0:0] {
        REG_CUTOFF = 1'b0,
        REG_TOTAL  = 1'b1
    } beq_reg_idx_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_CMP,
        BK_DONE
    } beq_back_state_t;

    typedef struct packed {
        logic [BAND_W-1:0] offset;
        logic              last_band;
        logic              overlong;
    } beq_tag_t;

    typedef logic [THR_W-1:0] beq_thr_rom_t [ROM_DEPTH];

    localparam logic [THR_W-1:0] THR_CAP = THR_W'((64'd1 << 46) + 64'd1);

    // Mantissas of the half-dB points, scaled by one billion.
    localparam logic [32:0] BEQ_MANT [10] = '{
        33'd891250938,  33'd1122018454, 33'd1412537545, 33'd1778279410,
        33'd2238721139, 33'd2818382931, 33'd3548133892, 33'd4466835922,
        33'd5623413252, 33'd7079457844
    };

    // Mean-square thresholds in Q30; entry k is the lower edge of code k.
    function automatic beq_thr_rom_t beq_build_thr_rom();
        beq_thr_rom_t rom;
        logic [63:0]  p;
        logic [63:0]  t;
        int           hi;
        int           j;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            hi = k / 10;
            j  = k % 10;
            p  = 64'(BEQ_MANT[j]) << 30;
            case (hi)
                0:  t = (p + 64'd999999999999999) / 64'd1000000000000000;
                1:  t = (p + 64'd99999999999999) / 64'd100000000000000;
                2:  t = (p + 64'd9999999999999) / 64'd10000000000000;
                3:  t = (p + 64'd999999999999) / 64'd1000000000000;
                4:  t = (p + 64'd99999999999) / 64'd100000000000;
                5:  t = (p + 64'd9999999999) / 64'd10000000000;
                6:  t = (p + 64'd999999999) / 64'd1000000000;
                7:  t = (p + 64'd99999999) / 64'd100000000;
                8:  t = (p + 64'd9999999) / 64'd10000000;
                9:  t = (p + 64'd999999) / 64'd1000000;
                10: t = (p + 64'd99999) / 64'd100000;
                default: t = 64'(THR_CAP);
            endcase
            if (t > 64'(THR_CAP)) begin
                t = 64'(THR_CAP);
            end
            rom[k] = THR_W'(t);
        end
        return rom;
    endfunction

    localparam beq_thr_rom_t BEQ_THR_ROM = beq_build_thr_rom();

endpackage

FILE: hw/rtl/beq_front.sv
// Front end: band filtering, squaring and per-band accumulation.
module beq_front import beq_pkg::*; #(
    parameter int MAX_BANDS    = 64,
    parameter int MAX_BAND_LEN = 256,
    parameter int CNT_W        = $clog2(MAX_BAND_LEN + 1),
    parameter int SUM_W        = SQ_W - 1 + CNT_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [COEF_W-1:0] coefficient,
    input  logic [BAND_W-1:0]        band_number,
    input  logic                     band_end,
    input  logic [CFG_W-1:0]         first_band,
    input  logic [CFG_W-1:0]         band_limit,
    output logic                     q_push,
    input  logic                     q_full,
    output logic [SUM_W-1:0]         q_sum,
    output logic [CNT_W-1:0]         q_count,
    output beq_tag_t                 q_tag
);

    logic              a_valid_reg;
    logic              a_valid_next;
    logic [SQ_W-1:0]   a_sq_reg;
    logic              a_last_reg;
    beq_tag_t          a_tag_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic              stall;
    logic              accept;
    logic              in_range;
    logic [COEF_W-1:0] mag;
    logic [SUM_W-1:0]  sum_upd;
    logic [CNT_W-1:0]  count_upd;
    logic              ovf_upd;
    logic              room;

    // A band-end beat waits in stage A while the queue has no room.
    assign stall  = a_valid_reg && a_last_reg && q_full;
    assign full   = stall;
    assign accept = push && !stall;

    assign in_range = ({1'b0, band_number} >= first_band)
                   && ({1'b0, band_number} < band_limit)
                   && (9'(band_number) < 9'(MAX_BANDS));

    assign mag = coefficient[COEF_W-1] ? COEF_W'(-coefficient) : COEF_W'(coefficient);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (!stall)
        begin
            a_valid_next = accept && in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            a_sq_reg            <= SQ_W'(mag * mag);
            a_last_reg          <= band_end;
            a_tag_reg.offset    <= band_number - first_band[BAND_W-1:0];
            a_tag_reg.last_band <= ((CFG_W'(band_number) + CFG_W'(1)) == band_limit);
            a_tag_reg.overlong  <= 1'b0;
        end
    end

    // Stage B: the band accumulators.
    assign room      = count_reg < CNT_W'(MAX_BAND_LEN);
    assign sum_upd   = room ? sum_reg + SUM_W'(a_sq_reg) : sum_reg;
    assign count_upd = room ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_upd   = ovf_reg || !room;

    assign q_push           = a_valid_reg && a_last_reg && !q_full;
    assign q_sum            = sum_upd;
    assign q_count          = count_upd;
    assign q_tag.offset     = a_tag_reg.offset;
    assign q_tag.last_band  = a_tag_reg.last_band;
    assign q_tag.overlong   = ovf_upd;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (a_valid_reg && !stall)
        begin
            if (a_last_reg)
            begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: hw/rtl/beq_fifo.sv
// Short register queue that carries finished band totals to the coder.
module beq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == (AW+1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/beq_back.sv
// Back end: binary search of the threshold table and the result register.
module beq_back import beq_pkg::*; #(
    parameter int CODE_LEVELS = 256,
    parameter int CNT_W       = 9,
    parameter int SUM_W       = 55
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [SUM_W-1:0]  q_sum,
    input  logic [CNT_W-1:0]  q_count,
    input  beq_tag_t          q_tag,
    output logic              empty,
    input  logic              pop,
    output logic [CODE_W-1:0] energy_code,
    output beq_tag_t          out_tag
);

    localparam int PROD_W = THR_W + CNT_W;
    localparam int BIT_W  = $clog2(CODE_W);

    beq_back_state_t   state_reg;
    beq_back_state_t   state_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  n_reg;
    beq_tag_t          tag_reg;
    logic [CODE_W-1:0] code_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    beq_tag_t          out_tag_reg;

    logic [CODE_W-1:0] cand;
    logic              pass;
    logic              load_out;

    assign cand = code_reg | (CODE_W'(1) << bit_reg);
    // Codes at or above the level count never win, which caps the result.
    assign pass = (9'(cand) < 9'(CODE_LEVELS)) && ({1'b0, sum_reg} >= prod_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_CMP;
            end
            BK_CMP:
            begin
                state_next = (bit_reg == '0) ? BK_DONE : BK_MUL;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop    = !q_empty;
            BK_MUL:  q_pop    = 1'b0;
            BK_CMP:  q_pop    = 1'b0;
            BK_DONE: load_out = !out_valid_reg || pop;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sum_reg  <= q_sum;
            n_reg    <= q_count;
            tag_reg  <= q_tag;
            code_reg <= '0;
            bit_reg  <= BIT_W'(CODE_W - 1);
        end
        if (state_reg == BK_MUL)
        begin
            prod_reg <= PROD_W'(n_reg) * PROD_W'(BEQ_THR_ROM[cand]);
        end
        if (state_reg == BK_CMP)
        begin
            if (pass)
            begin
                code_reg <= cand;
            end
            bit_reg <= bit_reg - BIT_W'(1);
        end
        if (load_out)
        begin
            out_code_reg <= code_reg;
            out_tag_reg  <= tag_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign energy_code = out_code_reg;
    assign out_tag     = out_tag_reg;

endmodule

FILE: hw/rtl/band_energy_db_quantizer_core.sv
// Top level of the band energy quantizer: configuration registers and the three stages.
//
// Usage: coefficients enter as beats on a queue-style port (push/full); a beat is
// taken on a clock edge with push high and full low. Beats of bands below first_band
// or at or above band_limit are dropped. On the band-end beat of a kept band, one
// result (energy_code, high_band_offset, final_band, overlong) is produced and shown
// on the result port while empty is low; pop takes it.
// The front end takes one coefficient per cycle while full is low. A finished band
// total passes through a four-entry queue to the coder, which runs an eight-step
// binary search over the threshold table, each step a multiply and then a compare.
// Sustained rate is one coefficient per cycle as long as bands are long enough on
// average for the coder to keep pace; shorter bands fill the queue and full then
// rises until the coder catches up. While pop is held low the finished result
// stays in the output register, the coder holds its next result, and the queue
// and front end keep working until the queue fills.
// Reset clears the accumulators, the queue and the output register, and sets
// first_band to 0 and band_limit to 64. The user must write the registers over
// APB at byte address 0 (first_band) and 4 (band_limit) only while the block is
// idle; the block itself does not enforce this.
module band_energy_db_quantizer_core import beq_pkg::*; #(
    parameter int MAX_BANDS    = 64,
    parameter int MAX_BAND_LEN = 256,
    parameter int CODE_LEVELS  = 256,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic signed [COEF_W-1:0] coefficient,
    input  logic [BAND_W-1:0]        band_number,
    input  logic                     band_end,
    output logic                     empty,
    input  logic                     pop,
    output logic [CODE_W-1:0]        energy_code,
    output logic [BAND_W-1:0]        high_band_offset,
    output logic                     final_band,
    output logic                     overlong
);

    localparam int CNT_W  = $clog2(MAX_BAND_LEN + 1);
    localparam int SUM_W  = SQ_W - 1 + CNT_W;
    localparam int ENTRY_W = SUM_W + CNT_W + $bits(beq_tag_t);

    logic [CFG_W-1:0]   cutoff_reg;
    logic [CFG_W-1:0]   cutoff_next;
    logic [CFG_W-1:0]   total_reg;
    logic [CFG_W-1:0]   total_next;
    beq_reg_idx_t       reg_sel;

    logic               fq_push;
    logic               fq_full;
    logic [SUM_W-1:0]   fq_sum;
    logic [CNT_W-1:0]   fq_count;
    beq_tag_t           fq_tag;
    logic               bq_pop;
    logic               bq_empty;
    logic [ENTRY_W-1:0] bq_data;
    logic [SUM_W-1:0]   bq_sum;
    logic [CNT_W-1:0]   bq_count;
    beq_tag_t           bq_tag;
    beq_tag_t           out_tag;

    assign reg_sel = beq_reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_comb
    begin
        cutoff_next = cutoff_reg;
        total_next  = total_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_CUTOFF: cutoff_next = pwdata[CFG_W-1:0];
                REG_TOTAL:  total_next  = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_CUTOFF: prdata = APB_DW'(cutoff_reg);
            REG_TOTAL:  prdata = APB_DW'(total_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
            total_reg  <= CFG_W'(64);
        end
        else
        begin
            cutoff_reg <= cutoff_next;
            total_reg  <= total_next;
        end
    end

    beq_front #(
        .MAX_BANDS    (MAX_BANDS),
        .MAX_BAND_LEN (MAX_BAND_LEN),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .coefficient (coefficient),
        .band_number (band_number),
        .band_end    (band_end),
        .first_band  (cutoff_reg),
        .band_limit  (total_reg),
        .q_push      (fq_push),
        .q_full      (fq_full),
        .q_sum       (fq_sum),
        .q_count     (fq_count),
        .q_tag       (fq_tag)
    );

    beq_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data ({fq_sum, fq_count, fq_tag}),
        .full    (fq_full),
        .rd_en   (bq_pop),
        .rd_data (bq_data),
        .empty   (bq_empty)
    );

    assign {bq_sum, bq_count, bq_tag} = bq_data;

    beq_back #(
        .CODE_LEVELS (CODE_LEVELS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (bq_empty),
        .q_pop       (bq_pop),
        .q_sum       (bq_sum),
        .q_count     (bq_count),
        .q_tag       (bq_tag),
        .empty       (empty),
        .pop         (pop),
        .energy_code (energy_code),
        .out_tag     (out_tag)
    );

    assign high_band_offset = out_tag.offset;
    assign final_band       = out_tag.last_band;
    assign overlong         = out_tag.overlong;

endmodule

FILE: hw/rtl/beq_checker.sv
// Port-level checks of the band energy quantizer and their binding to the top level.
module beq_checker import beq_pkg::*; #(
    parameter int CODE_LEVELS = 256
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [APB_AW-1:0]        paddr,
    input logic [APB_DW-1:0]        pwdata,
    input logic [APB_DW-1:0]        prdata,
    input logic                     pready,
    input logic                     empty,
    input logic                     pop,
    input logic [CODE_W-1:0]        energy_code,
    input logic [BAND_W-1:0]        high_band_offset,
    input logic                     final_band,
    input logic                     overlong
);

    // A waiting result stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(energy_code) && $stable(high_band_offset)
                              && $stable(final_band) && $stable(overlong)))
        else $error("result changed or vanished while stalled");

    // The code never reaches the level count.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (9'(energy_code) < 9'(CODE_LEVELS)))
        else $error("energy code above the top level");

    // A register reads back what was written to it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready) ##1 (paddr[2] == $past(paddr[2]))
        |-> (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])))
        else $error("register readback mismatch");

    // Only the register bits are ever driven on the read bus.
    assert property (@(posedge clk) disable iff (!rst_n)
        (prdata[APB_DW-1:CFG_W] == '0) && pready)
        else $error("read bus shows bits outside the registers");

endmodule

bind band_energy_db_quantizer_core beq_checker #(
    .CODE_LEVELS (CODE_LEVELS)
) u_beq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .empty            (empty),
    .pop              (pop),
    .energy_code      (energy_code),
    .high_band_offset (high_band_offset),
    .final_band       (final_band),
    .overlong         (overlong)
);

FILE: dv/band_energy_db_quantizer_core_tb.sv
// Self-checking testbench for the band energy dB quantizer: table-driven and random beats.
`timescale 1ns / 1ps

module band_energy_db_quantizer_core_tb import beq_pkg::*;;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_LEN       = 256;
    localparam int PHASES        = 13;
    localparam logic [63:0] EDGE_CAP = (64'd1 << 46) + 64'd1;

    // Half-dB mantissas scaled by one billion.
    localparam logic [63:0] HALF_DB_MANT [10] = '{
        64'd891250938,  64'd1122018454, 64'd1412537545, 64'd1778279410,
        64'd2238721139, 64'd2818382931, 64'd3548133892, 64'd4466835922,
        64'd5623413252, 64'd7079457844
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BAND_W-1:0] offset;
        logic              last_band;
        logic              over;
    } band_code_t;

    typedef struct packed {
        logic       pinned;
        band_code_t want;
    } item_note_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [BAND_W-1:0] band;
        logic              last;
        logic              pinned;
        band_code_t        want;
    } stim_row_t;

    localparam band_code_t NO_CODE = '0;

    // Rows with a typed code are silent bands, 0 dB, full scale and a tone below -60 dB.
    localparam stim_row_t DIR_ROWS [18] = '{
        '{24'h000000, 6'd0,  1'b1, 1'b1, '{8'd0,   6'd0,  1'b0, 1'b0}},
        '{24'h000001, 6'd5,  1'b1, 1'b1, '{8'd0,   6'd5,  1'b0, 1'b0}},
        '{24'h008000, 6'd10, 1'b1, 1'b1, '{8'd60,  6'd10, 1'b0, 1'b0}},
        '{24'hFF8000, 6'd11, 1'b1, 1'b1, '{8'd60,  6'd11, 1'b0, 1'b0}},
        '{24'h7FFFFF, 6'd63, 1'b1, 1'b1, '{8'd108, 6'd63, 1'b1, 1'b0}},
        '{24'h800000, 6'd63, 1'b1, 1'b1, '{8'd108, 6'd63, 1'b1, 1'b0}},
        '{24'h800000, 6'd62, 1'b1, 1'b1, '{8'd108, 6'd62, 1'b0, 1'b0}},
        '{24'hFFFFFF, 6'd20, 1'b0, 1'b0, NO_CODE},
        '{24'h555555, 6'd20, 1'b0, 1'b0, NO_CODE},
        '{24'hAAAAAA, 6'd20, 1'b1, 1'b0, NO_CODE},
        '{24'h123456, 6'd3,  1'b0, 1'b0, NO_CODE},
        '{24'hF00000, 6'd7,  1'b1, 1'b0, NO_CODE},
        '{24'h000100, 6'd30, 1'b0, 1'b0, NO_CODE},
        '{24'h000200, 6'd31, 1'b0, 1'b0, NO_CODE},
        '{24'h7FFFFF, 6'd32, 1'b1, 1'b0, NO_CODE},
        '{24'h000000, 6'd40, 1'b0, 1'b0, NO_CODE},
        '{24'h000000, 6'd40, 1'b1, 1'b1, '{8'd0,   6'd40, 1'b0, 1'b0}},
        '{24'h004000, 6'd41, 1'b1, 1'b0, NO_CODE}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;
    logic                     push = 1'b0;
    logic                     full;
    logic signed [COEF_W-1:0] coefficient = '0;
    logic [BAND_W-1:0]        band_number = '0;
    logic                     band_end = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [CODE_W-1:0]        energy_code;
    logic [BAND_W-1:0]        high_band_offset;
    logic                     final_band;
    logic                     overlong;

    // Predictor state and its copy of the registers.
    logic [55:0]  acc_energy = '0;
    int           acc_len = 0;
    logic         acc_spill = 1'b0;
    logic [6:0]   cfg_cutoff = 7'd0;
    logic [6:0]   cfg_total = 7'd64;
    logic [63:0]  db_edge [256];

    band_code_t   pending_codes [$];
    item_note_t   item_notes [$];

    int           cycles = 0;
    int           mismatches = 0;
    int           beats_in = 0;
    int           codes_seen = 0;
    int           settings = 0;
    int           phase_kept = 0;
    int           phase_sent = 0;
    int           steady_left = 0;
    logic         calm = 1'b0;

    band_energy_db_quantizer_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .coefficient      (coefficient),
        .band_number      (band_number),
        .band_end         (band_end),
        .empty            (empty),
        .pop              (pop),
        .energy_code      (energy_code),
        .high_band_offset (high_band_offset),
        .final_band       (final_band),
        .overlong         (overlong)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d codes outstanding.",
                     cycles, pending_codes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        end
    endtask

    // Accumulates one beat; returns 1 with the code when a kept band closes.
    function automatic logic predict_band_code(input logic [COEF_W-1:0] c,
                                               input logic [BAND_W-1:0] b,
                                               input logic e,
                                               output band_code_t r);
        int          top;
        logic [23:0] mag;
        logic [7:0]  lvl;
        top = (int'(cfg_total) < 64) ? int'(cfg_total) : 64;
        r = '0;
        if (int'(b) < int'(cfg_cutoff) || int'(b) >= top)
        begin
            return 1'b0;
        end
        mag = c[23] ? (~c + 24'd1) : c;
        if (acc_len < MAX_LEN)
        begin
            acc_energy += 56'(mag) * 56'(mag);
            acc_len++;
        end
        else
        begin
            acc_spill = 1'b1;
        end
        if (!e)
        begin
            return 1'b0;
        end
        lvl = 8'd0;
        for (int k = 1; k < 256; k++)
        begin
            if (64'(acc_energy) >= 64'(acc_len) * db_edge[k])
            begin
                lvl = 8'(k);
            end
            else
            begin
                break;
            end
        end
        r.code      = lvl;
        r.offset    = 6'(b - cfg_cutoff);
        r.last_band = (int'(b) + 1 == int'(cfg_total));
        r.over      = acc_spill;
        acc_energy  = '0;
        acc_len     = 0;
        acc_spill   = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        item_note_t nt;
        band_code_t guess;
        band_code_t head;
        if (rst_n && push && !full)
        begin
            beats_in++;
            nt = '0;
            if (item_notes.size() != 0)
            begin
                nt = item_notes.pop_front();
            end
            if (predict_band_code(coefficient, band_number, band_end, guess))
            begin
                pending_codes.push_back(nt.pinned ? nt.want : guess);
            end
        end
        if (rst_n && pop && !empty)
        begin
            if (pending_codes.size() == 0)
            begin
                note_mismatch($sformatf("unexpected code %0d offset %0d final %0d over %0d",
                                        energy_code, high_band_offset, final_band, overlong));
            end
            else
            begin
                head = pending_codes.pop_front();
                codes_seen++;
                if (head.code !== energy_code || head.offset !== high_band_offset ||
                    head.last_band !== final_band || head.over !== overlong)
                begin
                    note_mismatch($sformatf(
                        "code %0d/%0d offset %0d/%0d final %0d/%0d over %0d/%0d (exp/act)",
                        head.code, energy_code, head.offset, high_band_offset,
                        head.last_band, final_band, head.over, overlong));
                end
            end
        end
    end

    // Result side: runs of pop interrupted by short stalls.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send_coef(input logic [COEF_W-1:0] c, input logic [BAND_W-1:0] b,
                             input logic e, input logic pinned, input band_code_t want);
        if (steady_left > 0)
        begin
            steady_left--;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            steady_left = $urandom_range(20, 40);
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_notes.push_back(item_note_t'{pinned, want});
        push        <= 1'b1;
        coefficient <= c;
        band_number <= b;
        band_end    <= e;
        @(posedge clk);
        while (full) @(posedge clk);
        phase_sent++;
        if (int'(b) >= int'(cfg_cutoff) && int'(b) < int'(cfg_total) && b < 64)
        begin
            phase_kept++;
        end
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        logic [23:0] m;
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            2, 3: return 24'($urandom);
            default:
            begin
                m = 24'($urandom_range(0, 24'h7FFFFF) >> $urandom_range(0, 23));
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    // One band of beats; a nonzero length gives a clean band of that length, mostly in the kept range.
    task automatic band_run(input int fixed_len);
        int          lo;
        int          hi;
        int          len;
        logic [5:0]  band;
        logic [5:0]  b;
        logic        e;
        lo = int'(cfg_cutoff);
        hi = (int'(cfg_total) < 64) ? int'(cfg_total) : 64;
        if (lo < hi && $urandom_range(0, 7) != 0)
        begin
            band = 6'($urandom_range(lo, hi - 1));
        end
        else
        begin
            band = 6'($urandom_range(0, 63));
        end
        if (fixed_len > 0)
        begin
            len = fixed_len;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            len = $urandom_range(25, 60);
        end
        else
        begin
            len = $urandom_range(1, 24);
        end
        for (int i = 0; i < len; i++)
        begin
            b = band;
            if (i == len - 1)
            begin
                e = (fixed_len > 0) || ($urandom_range(0, 15) != 0);
            end
            else
            begin
                e = (fixed_len == 0) && ($urandom_range(0, 31) == 0);
            end
            // Stray band numbers exercise pooling across bands.
            if (fixed_len == 0 && $urandom_range(0, 15) == 0)
            begin
                b = 6'($urandom_range(0, 63));
            end
            send_coef(pick_coef(), b, e, 1'b0, NO_CODE);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_codes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write over APB, then read the register back.
    task automatic program_reg(input beq_reg_idx_t idx, input logic [6:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(val))
        begin
            note_mismatch($sformatf("register %s read %0h, wrote %0h", idx.name(), prdata, val));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_CUTOFF)
        begin
            cfg_cutoff = val;
        end
        else
        begin
            cfg_total = val;
        end
    endtask

    initial
    begin
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] t;
        logic [6:0]  cut;
        logic [6:0]  tot;
        int          hi;
        db_edge[0] = '0;
        for (int k = 1; k < 256; k++)
        begin
            hi = k / 10;
            if (hi >= 11)
            begin
                db_edge[k] = EDGE_CAP;
            end
            else
            begin
                p = HALF_DB_MANT[k % 10] << 30;
                d = 64'd1;
                repeat (15 - hi) d = d * 64'd10;
                t = (p + d - 64'd1) / d;
                db_edge[k] = (t > EDGE_CAP) ? EDGE_CAP : t;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settings++;
        foreach (DIR_ROWS[i])
        begin
            send_coef(DIR_ROWS[i].coef, DIR_ROWS[i].band, DIR_ROWS[i].last,
                      DIR_ROWS[i].pinned, DIR_ROWS[i].want);
        end
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:  begin cut = 7'd0;  tot = 7'd64; end
                1:  begin cut = 7'd0;  tot = 7'd0;  end
                2:  begin cut = 7'd64; tot = 7'd64; end
                3:  begin cut = 7'd9;  tot = 7'd9;  end
                4:  begin cut = 7'd0;  tot = 7'd1;  end
                5:  begin cut = 7'd63; tot = 7'd64; end
                6:  begin cut = 7'd20; tot = 7'd40; end
                7:  begin cut = 7'd1;  tot = 7'd63; end
                8:  begin cut = 7'd64; tot = 7'd0;  end
                12: begin cut = 7'd0;  tot = 7'd64; end
                default:
                begin
                    cut = 7'($urandom_range(0, 48));
                    tot = 7'($urandom_range(0, 64));
                end
            endcase
            // The last phase runs with both ports free of random stalls from the testbench.
            calm = (ph == PHASES - 1);
            program_reg(REG_CUTOFF, cut);
            program_reg(REG_TOTAL, tot);
            settings++;
            phase_kept = 0;
            phase_sent = 0;
            if (ph == 0)
            begin
                // Exactly full length, then just past it.
                band_run(MAX_LEN);
                band_run($urandom_range(MAX_LEN + 1, MAX_LEN + 6));
                phase_kept = 0;
            end
            if (int'(cut) < ((int'(tot) < 64) ? int'(tot) : 64))
            begin
                while (phase_kept < 12) band_run(0);
            end
            else
            begin
                while (phase_sent < 8) band_run(0);
            end
            settle();
        end

        if (pending_codes.size() != 0)
        begin
            note_mismatch($sformatf("%0d codes never arrived", pending_codes.size()));
        end
        $display("Checked %0d band codes from %0d coefficient beats under %0d register settings.",
                 codes_seen, beats_in, settings);
        $display("Mismatches: %0d; silent, full-scale, pooled, overlong and dropped bands seen.",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/beq_pkg.sv
hw/rtl/beq_front.sv
hw/rtl/beq_fifo.sv
hw/rtl/beq_back.sv
hw/rtl/band_energy_db_quantizer_core.sv
hw/rtl/beq_checker.sv
dv/band_energy_db_quantizer_core_tb.sv
